@@ rtl/ethtcp_pkg.sv @@
// ============================================================================
// ethtcp_pkg
// Shared types and constants of the Ethernet/IP/TCP header extractor.
// ============================================================================
`default_nettype none

package ethtcp_pkg;

    // Byte counter saturates here; its width follows from the limit
    localparam int FRAME_COUNT_LIMIT = 16383;
    localparam int COUNT_W           = $clog2(FRAME_COUNT_LIMIT + 1);

    // Frame layout
    localparam int POS_TYPE_HI   = 12;
    localparam int POS_TYPE_LO   = 13;
    localparam int POS_VER_IHL   = 14;
    localparam int POS_FRAG_HI   = 20;
    localparam int POS_FRAG_LO   = 21;
    localparam int POS_V4_PROTO  = 23;
    localparam int POS_V6_NEXT   = 20;
    localparam int ADDR_FIRST    = 22;
    localparam int ADDR_BYTES    = 32;
    localparam int ETH_HDR_LEN   = 14;
    localparam int V6_TCP_START  = 54;
    localparam int TCP_BYTES     = 12;
    localparam int MIN_FRAME_LEN = 34;
    localparam int V4_TCP_EXTRA  = 26;
    localparam int V6_MIN_LEN    = 66;

    localparam logic [15:0] ETHERTYPE_V4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_V6 = 16'h86dd;
    localparam logic [7:0]  TCP_PROTOCOL = 8'd6;
    localparam logic [3:0]  IP_VERSION_4 = 4'd4;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_TOO_SHORT = 3'd1,
        STATUS_NOT_IP    = 3'd2,
        STATUS_BAD_VER   = 3'd3,
        STATUS_FRAGMENT  = 3'd4,
        STATUS_NOT_TCP   = 3'd5
    } status_t;

    // Header fields as they stand after the current byte
    typedef struct packed {
        logic [COUNT_W-1:0]      length;
        logic [15:0]             frame_type;
        logic [7:0]              ver_ihl;
        logic [12:0]             frag_offset;
        logic [7:0]              protocol;
        logic [ADDR_BYTES*8-1:0] addr_bytes;
        logic [TCP_BYTES*8-1:0]  tcp_bytes;
    } fields_t;

endpackage

`default_nettype wire

@@ rtl/ethtcp_if.sv @@
// ============================================================================
// ethtcp_if
// Valid/ready channels: frame bytes in, header verdicts out.
// ============================================================================
`default_nettype none

interface ethtcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ethtcp_result_if;
    logic                 valid;
    logic                 ready;
    ethtcp_pkg::status_t  status;
    logic                 is_ipv6;
    logic [63:0]          source_address_high;
    logic [63:0]          source_address_low;
    logic [63:0]          destination_address_high;
    logic [63:0]          destination_address_low;
    logic [15:0]          source_port;
    logic [15:0]          destination_port;
    logic [31:0]          sequence_number;
    logic [31:0]          acknowledge_number;

    modport source (
        output valid, output status, output is_ipv6,
        output source_address_high, output source_address_low,
        output destination_address_high, output destination_address_low,
        output source_port, output destination_port,
        output sequence_number, output acknowledge_number,
        input ready
    );
    modport sink (
        input valid, input status, input is_ipv6,
        input source_address_high, input source_address_low,
        input destination_address_high, input destination_address_low,
        input source_port, input destination_port,
        input sequence_number, input acknowledge_number,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/eth_ip_tcp_header_extractor.sv @@
// ============================================================================
// eth_ip_tcp_header_extractor
// Parses Ethernet/IPv4/IPv6/TCP headers from a byte stream, one verdict per frame.
// ============================================================================
//
//  Channel   Dir  Moves               Payload
//  frame     in   one frame byte      frame_byte, last_byte
//  verdict   out  one verdict/frame   status, is_ipv6, addresses, ports, seq, ack
//
//  One byte per cycle while no verdict stalls; a byte passes an input register,
//  then the capture and check logic, and a last byte lands in the result
//  register once that register has room. Reset clears the byte counter and
//  both valid flags. A stalled verdict holds only a last byte in the input
//  register, which then stalls the input; other bytes keep flowing.
// ============================================================================
`default_nettype none

module eth_ip_tcp_header_extractor (
    input  wire logic         clk,
    input  wire logic         rst_n,
    ethtcp_byte_if.sink       frame,
    ethtcp_result_if.source   verdict
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                advance;
    logic                slot_free;
    ethtcp_pkg::fields_t fields;

    // A last byte needs room in the result register
    assign advance     = in_valid_reg && (!in_last_reg || slot_free);
    assign frame.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (frame.ready)
            in_valid_reg <= frame.valid;
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_byte_reg <= frame.frame_byte;
            in_last_reg <= frame.last_byte;
        end
    end

    ethtcp_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .frame_byte (in_byte_reg),
        .last_byte  (in_last_reg),
        .fields     (fields)
    );

    ethtcp_verdict u_verdict (
        .clk       (clk),
        .rst_n     (rst_n),
        .finish    (advance && in_last_reg),
        .fields    (fields),
        .slot_free (slot_free),
        .result    (verdict)
    );

endmodule

`default_nettype wire

@@ rtl/ethtcp_capture.sv @@
// ============================================================================
// ethtcp_capture
// Byte counter and position-addressed capture of the header fields.
// ============================================================================
`default_nettype none

module ethtcp_capture (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic [7:0]          frame_byte,
    input  wire logic                last_byte,
    output ethtcp_pkg::fields_t      fields
);

    localparam int CW = ethtcp_pkg::COUNT_W;
    localparam int AB = ethtcp_pkg::ADDR_BYTES;
    localparam int TB = ethtcp_pkg::TCP_BYTES;

    logic [CW-1:0]   count_reg;
    logic [15:0]     type_reg,  type_next;
    logic [7:0]      ver_reg,   ver_next;
    logic [12:0]     frag_reg,  frag_next;
    logic [7:0]      proto_reg, proto_next;
    logic [AB*8-1:0] addr_reg,  addr_next;
    logic [TB*8-1:0] tcp_reg,   tcp_next;
    logic [CW-1:0]   length_next;
    logic [CW-1:0]   tcp_start;
    logic [CW-1:0]   tcp_offset;
    logic            tcp_hit;
    logic            is_v6;

    // Length including the current byte, saturating
    assign length_next = (count_reg < CW'(ethtcp_pkg::FRAME_COUNT_LIMIT))
                       ? count_reg + CW'(1) : CW'(ethtcp_pkg::FRAME_COUNT_LIMIT);

    // EtherType, version byte and fragment offset
    always_comb
    begin
        type_next = type_reg;
        if (count_reg == CW'(ethtcp_pkg::POS_TYPE_HI))
            type_next[15:8] = frame_byte;
        if (count_reg == CW'(ethtcp_pkg::POS_TYPE_LO))
            type_next[7:0] = frame_byte;

        ver_next = (count_reg == CW'(ethtcp_pkg::POS_VER_IHL)) ? frame_byte : ver_reg;

        frag_next = frag_reg;
        if (count_reg == CW'(ethtcp_pkg::POS_FRAG_HI))
            frag_next[12:8] = frame_byte[4:0];
        if (count_reg == CW'(ethtcp_pkg::POS_FRAG_LO))
            frag_next[7:0] = frame_byte;
    end

    assign is_v6 = (type_next == ethtcp_pkg::ETHERTYPE_V6);

    // Protocol or next-header byte, position depends on IP version
    always_comb
    begin
        proto_next = proto_reg;
        if ((is_v6 && count_reg == CW'(ethtcp_pkg::POS_V6_NEXT)) ||
            (!is_v6 && count_reg == CW'(ethtcp_pkg::POS_V4_PROTO)))
            proto_next = frame_byte;
    end

    // Address bytes, first byte in the top lane
    always_comb
    begin
        addr_next = addr_reg;
        for (int k = 0; k < AB; k++)
        begin
            if (count_reg == CW'(ethtcp_pkg::ADDR_FIRST + k))
                addr_next[(AB-1-k)*8 +: 8] = frame_byte;
        end
    end

    // TCP bytes follow the IP header
    assign tcp_start  = is_v6 ? CW'(ethtcp_pkg::V6_TCP_START)
                              : CW'(ethtcp_pkg::ETH_HDR_LEN) + CW'({ver_next[3:0], 2'b00});
    assign tcp_offset = count_reg - tcp_start;
    assign tcp_hit    = (count_reg >= tcp_start) && (tcp_offset < CW'(TB));

    always_comb
    begin
        tcp_next = tcp_reg;
        for (int k = 0; k < TB; k++)
        begin
            if (tcp_hit && tcp_offset == CW'(k))
                tcp_next[(TB-1-k)*8 +: 8] = frame_byte;
        end
    end

    // Advance counter; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (advance)
            count_reg <= last_byte ? '0 : length_next;
    end

    // Hold captured fields
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            type_reg  <= type_next;
            ver_reg   <= ver_next;
            frag_reg  <= frag_next;
            proto_reg <= proto_next;
            addr_reg  <= addr_next;
            tcp_reg   <= tcp_next;
        end
    end

    assign fields.length      = length_next;
    assign fields.frame_type  = type_next;
    assign fields.ver_ihl     = ver_next;
    assign fields.frag_offset = frag_next;
    assign fields.protocol    = proto_next;
    assign fields.addr_bytes  = addr_next;
    assign fields.tcp_bytes   = tcp_next;

endmodule

`default_nettype wire

@@ rtl/ethtcp_verdict.sv @@
// ============================================================================
// ethtcp_verdict
// Frame checks and the result register on the output channel.
// ============================================================================
`default_nettype none

module ethtcp_verdict (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                finish,
    input  wire ethtcp_pkg::fields_t fields,
    output logic                     slot_free,
    ethtcp_result_if.source          result
);

    localparam int CW = ethtcp_pkg::COUNT_W;

    ethtcp_pkg::status_t status_next;
    logic                is_v4;
    logic                is_v6;
    logic [CW-1:0]       v4_need;

    logic                valid_reg;
    ethtcp_pkg::status_t status_reg;
    logic                v6_reg;
    logic [255:0]        addr_reg;
    logic [95:0]         tcp_reg;

    assign is_v4   = (fields.frame_type == ethtcp_pkg::ETHERTYPE_V4);
    assign is_v6   = (fields.frame_type == ethtcp_pkg::ETHERTYPE_V6);
    assign v4_need = CW'(ethtcp_pkg::V4_TCP_EXTRA) + CW'({fields.ver_ihl[3:0], 2'b00});

    // Checks in order of precedence
    always_comb
    begin
        status_next = ethtcp_pkg::STATUS_OK;
        priority if (fields.length < CW'(ethtcp_pkg::MIN_FRAME_LEN))
            status_next = ethtcp_pkg::STATUS_TOO_SHORT;
        else if (is_v4)
        begin
            priority if (fields.ver_ihl[7:4] != ethtcp_pkg::IP_VERSION_4)
                status_next = ethtcp_pkg::STATUS_BAD_VER;
            else if (fields.frag_offset != '0)
                status_next = ethtcp_pkg::STATUS_FRAGMENT;
            else if (fields.protocol != ethtcp_pkg::TCP_PROTOCOL)
                status_next = ethtcp_pkg::STATUS_NOT_TCP;
            else if (v4_need > fields.length)
                status_next = ethtcp_pkg::STATUS_TOO_SHORT;
            else
                status_next = ethtcp_pkg::STATUS_OK;
        end
        else if (is_v6)
        begin
            priority if (fields.protocol != ethtcp_pkg::TCP_PROTOCOL)
                status_next = ethtcp_pkg::STATUS_NOT_TCP;
            else if (fields.length < CW'(ethtcp_pkg::V6_MIN_LEN))
                status_next = ethtcp_pkg::STATUS_TOO_SHORT;
            else
                status_next = ethtcp_pkg::STATUS_OK;
        end
        else
            status_next = ethtcp_pkg::STATUS_NOT_IP;
    end

    assign slot_free = !valid_reg || result.ready;

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (finish)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg <= status_next;
            v6_reg     <= is_v6;
            addr_reg   <= fields.addr_bytes;
            tcp_reg    <= fields.tcp_bytes;
        end
    end

    // Drop every field but the status of a rejected frame to zero
    always_comb
    begin
        result.valid                    = valid_reg;
        result.status                   = status_reg;
        result.is_ipv6                  = 1'b0;
        result.source_address_high      = '0;
        result.source_address_low       = '0;
        result.destination_address_high = '0;
        result.destination_address_low  = '0;
        result.source_port              = '0;
        result.destination_port         = '0;
        result.sequence_number          = '0;
        result.acknowledge_number       = '0;
        if (status_reg == ethtcp_pkg::STATUS_OK)
        begin
            result.is_ipv6            = v6_reg;
            result.source_port        = tcp_reg[95:80];
            result.destination_port   = tcp_reg[79:64];
            result.sequence_number    = tcp_reg[63:32];
            result.acknowledge_number = tcp_reg[31:0];
            if (v6_reg)
            begin
                result.source_address_high      = addr_reg[255:192];
                result.source_address_low       = addr_reg[191:128];
                result.destination_address_high = addr_reg[127:64];
                result.destination_address_low  = addr_reg[63:0];
            end
            else
            begin
                result.source_address_low      = {32'd0, addr_reg[223:192]};
                result.destination_address_low = {32'd0, addr_reg[191:160]};
            end
        end
    end

endmodule

`default_nettype wire

@@ verif/ethtcp_verdict_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// ethtcp_verdict_checker
// Watches both channels of the header extractor. Every accepted frame byte
// advances a private parser of the frame; the byte marked last queues the
// verdict that the frame should get. Every accepted verdict is compared
// field by field with the oldest queued one.
// ============================================================================

module ethtcp_verdict_checker (
    input  logic            clk,
    input  logic            rst_n,
    ethtcp_byte_if          frame,
    ethtcp_result_if        verdict,
    output int unsigned     error_count,
    output int unsigned     pending
);

    // Frame layout and codes, kept apart from the design's own package values
    localparam int unsigned FRAME_LIMIT  = 16383;
    localparam int unsigned AT_TYPE_HI   = 12;
    localparam int unsigned AT_TYPE_LO   = 13;
    localparam int unsigned AT_VER_IHL   = 14;
    localparam int unsigned AT_FRAG_HI   = 20;
    localparam int unsigned AT_FRAG_LO   = 21;
    localparam int unsigned AT_V6_NEXT   = 20;
    localparam int unsigned AT_V4_PROTO  = 23;
    localparam int unsigned AT_ADDR      = 22;
    localparam int unsigned ADDR_LEN     = 32;
    localparam int unsigned ETH_LEN      = 14;
    localparam int unsigned AT_V6_TCP    = 54;
    localparam int unsigned TCP_LEN      = 12;
    localparam int unsigned MIN_LEN      = 34;
    localparam int unsigned V4_TCP_NEED  = 26;
    localparam int unsigned V6_NEED      = 66;

    localparam logic [15:0] TYPE_IPV4    = 16'h0800;
    localparam logic [15:0] TYPE_IPV6    = 16'h86dd;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [3:0]  IPV4_VERSION = 4'd4;

    typedef struct packed {
        ethtcp_pkg::status_t status;
        logic                is_ipv6;
        logic [63:0]         src_high;
        logic [63:0]         src_low;
        logic [63:0]         dst_high;
        logic [63:0]         dst_low;
        logic [15:0]         src_port;
        logic [15:0]         dst_port;
        logic [31:0]         seq_num;
        logic [31:0]         ack_num;
    } verdict_t;

    verdict_t     verdicts_due [$];

    // Parser state; address and segment bytes sit big-endian, first byte on top
    logic [13:0]  byte_pos;
    logic [15:0]  type_word;
    logic [7:0]   ver_ihl;
    logic [12:0]  frag_offset;
    logic [7:0]   l4_proto;
    logic [255:0] addr_bytes;
    logic [95:0]  tcp_bytes;
    int unsigned  mismatches = 0;

    // Capture one frame byte; on the last one, queue the frame's verdict
    task automatic parse_frame_byte(input logic [7:0] b, input logic is_last);
        int unsigned pos;
        int unsigned tcp_at;
        int unsigned len;
        logic        ipv6;
        verdict_t    v;

        pos = 32'(byte_pos);
        if (pos == AT_TYPE_HI)
            type_word[15:8] = b;
        if (pos == AT_TYPE_LO)
            type_word[7:0] = b;
        ipv6 = (type_word == TYPE_IPV6);
        if (pos == AT_VER_IHL)
            ver_ihl = b;
        if (pos == AT_FRAG_HI)
            frag_offset[12:8] = b[4:0];
        if (pos == AT_FRAG_LO)
            frag_offset[7:0] = b;
        if ((ipv6 && pos == AT_V6_NEXT) || (!ipv6 && pos == AT_V4_PROTO))
            l4_proto = b;
        if (pos >= AT_ADDR && pos < AT_ADDR + ADDR_LEN)
            addr_bytes[255 - 8 * (pos - AT_ADDR) -: 8] = b;

        // Segment fields follow the IP header: a fixed position for IPv6, the IHL length for IPv4
        tcp_at = ipv6 ? AT_V6_TCP : ETH_LEN + 4 * ver_ihl[3:0];
        if (pos >= tcp_at && pos < tcp_at + TCP_LEN)
            tcp_bytes[95 - 8 * (pos - tcp_at) -: 8] = b;

        len = (pos < FRAME_LIMIT) ? pos + 1 : FRAME_LIMIT;
        if (!is_last)
            byte_pos = len[13:0];
        else
        begin
            byte_pos = '0;
            v = '0;
            if (len < MIN_LEN)
                v.status = ethtcp_pkg::STATUS_TOO_SHORT;
            else if (type_word == TYPE_IPV4)
            begin
                if (ver_ihl[7:4] != IPV4_VERSION)
                    v.status = ethtcp_pkg::STATUS_BAD_VER;
                else if (frag_offset != '0)
                    v.status = ethtcp_pkg::STATUS_FRAGMENT;
                else if (l4_proto != PROTO_TCP)
                    v.status = ethtcp_pkg::STATUS_NOT_TCP;
                else if (V4_TCP_NEED + 4 * ver_ihl[3:0] > len)
                    v.status = ethtcp_pkg::STATUS_TOO_SHORT;
            end
            else if (ipv6)
            begin
                if (l4_proto != PROTO_TCP)
                    v.status = ethtcp_pkg::STATUS_NOT_TCP;
                else if (len < V6_NEED)
                    v.status = ethtcp_pkg::STATUS_TOO_SHORT;
            end
            else
                v.status = ethtcp_pkg::STATUS_NOT_IP;

            // Report fields only for an accepted segment
            if (v.status == ethtcp_pkg::STATUS_OK)
            begin
                v.is_ipv6 = ipv6;
                if (ipv6)
                begin
                    v.src_high = addr_bytes[255:192];
                    v.src_low  = addr_bytes[191:128];
                    v.dst_high = addr_bytes[127:64];
                    v.dst_low  = addr_bytes[63:0];
                end
                else
                begin
                    v.src_low = {32'h0, addr_bytes[223:192]};
                    v.dst_low = {32'h0, addr_bytes[191:160]};
                end
                v.src_port = tcp_bytes[95:80];
                v.dst_port = tcp_bytes[79:64];
                v.seq_num  = tcp_bytes[63:32];
                v.ack_num  = tcp_bytes[31:0];
            end
            verdicts_due.push_back(v);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare an accepted verdict with the oldest outstanding frame
    task automatic check_verdict();
        verdict_t want;

        if (verdicts_due.size() == 0)
        begin
            $error("verdict accepted with no frame outstanding");
            mismatches++;
        end
        else
        begin
            want = verdicts_due.pop_front();
            check_field("status", 64'(want.status), 64'(verdict.status));
            check_field("is_ipv6", 64'(want.is_ipv6), 64'(verdict.is_ipv6));
            check_field("source_address_high", want.src_high, verdict.source_address_high);
            check_field("source_address_low", want.src_low, verdict.source_address_low);
            check_field("destination_address_high", want.dst_high,
                        verdict.destination_address_high);
            check_field("destination_address_low", want.dst_low,
                        verdict.destination_address_low);
            check_field("source_port", 64'(want.src_port), 64'(verdict.source_port));
            check_field("destination_port", 64'(want.dst_port),
                        64'(verdict.destination_port));
            check_field("sequence_number", 64'(want.seq_num),
                        64'(verdict.sequence_number));
            check_field("acknowledge_number", 64'(want.ack_num),
                        64'(verdict.acknowledge_number));
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos    = '0;
            type_word   = '0;
            ver_ihl     = '0;
            frag_offset = '0;
            l4_proto    = '0;
            addr_bytes  = '0;
            tcp_bytes   = '0;
            verdicts_due.delete();
        end
        else
        begin
            // Take the verdict first: a byte at this same edge cannot be its source
            if (verdict.valid && verdict.ready)
                check_verdict();
            if (frame.valid && frame.ready)
                parse_frame_byte(frame.frame_byte, frame.last_byte);
        end
        error_count <= mismatches;
        pending     <= verdicts_due.size();
    end

endmodule

@@ verif/eth_ip_tcp_header_extractor_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// eth_ip_tcp_header_extractor_tb
// Feeds Ethernet frames byte by byte into the header extractor: a directed
// set of header corner cases, then random frames, mostly well-formed IPv4
// and IPv6 TCP segments, mixed with broken headers, short frames and noise.
// Both channels idle at random; once the verdict side holds off long enough
// to stall the frame input. The checker beside the block judges each verdict.
// ============================================================================

module eth_ip_tcp_header_extractor_tb;

    localparam int unsigned CLK_HALF        = 10;
    localparam int unsigned RESET_CYCLES    = 4;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned IDLE_PCT        = 11;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned TOTAL_BYTES     = 950;
    localparam int unsigned CALM_FIRST      = 0;
    localparam int unsigned CALM_END        = 3;
    localparam int unsigned PRESSURE_AT     = 3;
    localparam int unsigned PRESSURE_FRAMES = 24;

    // Frame layout
    localparam int unsigned OFS_TYPE    = 12;
    localparam int unsigned OFS_VER     = 14;
    localparam int unsigned OFS_FRAG    = 20;
    localparam int unsigned OFS_NEXT6   = 20;
    localparam int unsigned OFS_PROTO4  = 23;
    localparam int unsigned MIN_LEN     = 34;
    localparam int unsigned V4_NEED     = 26;
    localparam int unsigned V6_NEED     = 66;

    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_IPV6    = 16'h86dd;
    localparam logic [15:0] ETH_ARP     = 16'h0806;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [3:0]  IPV4_VER    = 4'd4;
    localparam logic [3:0]  IPV6_VER    = 4'd6;
    localparam logic [7:0]  FLAG_MASK   = 8'he0;

    logic        clk;
    logic        rst_n;
    logic        calm;
    logic        hold_trigger;
    int unsigned error_count;
    int unsigned pending;
    int unsigned bytes_sent;
    logic [7:0]  pkt [$];

    ethtcp_byte_if   frame_ch ();
    ethtcp_result_if verdict_ch ();

    eth_ip_tcp_header_extractor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_ch),
        .verdict (verdict_ch)
    );

    ethtcp_verdict_checker verdict_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame       (frame_ch),
        .verdict     (verdict_ch),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Verdict side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned hold_left;
        logic        hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        verdict_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_trigger && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (!rst_n)
                verdict_ch.ready <= 1'b0;
            else if (hold_left != 0)
            begin
                hold_left--;
                verdict_ch.ready <= 1'b0;
            end
            else
                verdict_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Offer one byte, idling at random first; return once it is accepted
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= value;
        frame_ch.last_byte  <= is_last;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_frame();
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
        bytes_sent += pkt.size();
    endtask

    task automatic set_type(input logic [15:0] type_code);
        pkt[OFS_TYPE]     = type_code[15:8];
        pkt[OFS_TYPE + 1] = type_code[7:0];
    endtask

    task automatic fill(input int unsigned lo, input int unsigned hi, input logic [7:0] value);
        for (int unsigned i = lo; i <= hi && i < pkt.size(); i++)
            pkt[i] = value;
    endtask

    // Random frame with a good TCP header for the given IP version
    task automatic build_tcp(input logic v6, input logic [3:0] hl, input int unsigned len);
        pkt.delete();
        repeat (len)
            pkt.push_back(8'($urandom_range(0, 255)));
        if (len > OFS_TYPE + 1)
            set_type(v6 ? ETH_IPV6 : ETH_IPV4);
        if (v6)
        begin
            if (len > OFS_NEXT6)
                pkt[OFS_NEXT6] = PROTO_TCP;
        end
        else
        begin
            if (len > OFS_VER)
                pkt[OFS_VER] = {IPV4_VER, hl};
            // keep the flags, clear the fragment offset
            if (len > OFS_FRAG + 1)
            begin
                pkt[OFS_FRAG]     = pkt[OFS_FRAG] & FLAG_MASK;
                pkt[OFS_FRAG + 1] = 8'h00;
            end
            if (len > OFS_PROTO4)
                pkt[OFS_PROTO4] = PROTO_TCP;
        end
    endtask

    // Mostly good segments, then broken headers, noise and runts
    task automatic build_random();
        int unsigned pick;
        int unsigned hl;
        int unsigned need;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            hl   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
            need = V4_NEED + 4 * hl;
            len  = need + $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0)
                len = need - 1;
            if (len < MIN_LEN)
                len = MIN_LEN + $urandom_range(0, 4);
            build_tcp(1'b0, hl[3:0], len);
        end
        else if (pick < 65)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(MIN_LEN, V6_NEED - 1);
            else
                len = V6_NEED + $urandom_range(0, 20);
            build_tcp(1'b1, 4'd0, len);
        end
        else if (pick < 82)
        begin
            // corrupt one header byte of an otherwise good frame
            build_tcp(1'($urandom_range(0, 1)), 4'd5, $urandom_range(MIN_LEN, 90));
            case ($urandom_range(0, 5))
                0: pkt[OFS_TYPE]     = 8'($urandom_range(0, 255));
                1: pkt[OFS_TYPE + 1] = 8'($urandom_range(0, 255));
                2: pkt[OFS_VER]      = 8'($urandom_range(0, 255));
                3: pkt[OFS_FRAG]     = 8'($urandom_range(0, 255));
                4: pkt[OFS_FRAG + 1] = 8'($urandom_range(0, 255));
                default: pkt[OFS_PROTO4] = 8'($urandom_range(0, 255));
            endcase
        end
        else if (pick < 92)
        begin
            len = $urandom_range(1, 100);
            pkt.delete();
            repeat (len)
                pkt.push_back(8'($urandom_range(0, 255)));
        end
        else
            build_tcp(1'($urandom_range(0, 1)), 4'd5, $urandom_range(1, MIN_LEN - 1));
    endtask

    initial
    begin : stimulus
        int unsigned frames;
        rst_n               <= 1'b0;
        calm                <= 1'b0;
        hold_trigger        <= 1'b0;
        frame_ch.valid      <= 1'b0;
        frame_ch.frame_byte <= '0;
        frame_ch.last_byte  <= 1'b0;
        bytes_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Runts: a lone last byte, and one byte under the minimum
        build_tcp(1'b0, 4'd5, 1);
        fill(0, 0, 8'hff);
        send_frame();
        build_tcp(1'b0, 4'd5, MIN_LEN - 1);
        send_frame();

        // Shortest IPv4 segment (addresses from 26, TCP 34..45) with all ones,
        // then one byte short
        build_tcp(1'b0, 4'd5, 46);
        fill(26, 45, 8'hff);
        send_frame();
        build_tcp(1'b0, 4'd5, 45);
        send_frame();

        // Longest IPv4 header, with just room for the segment fields
        build_tcp(1'b0, 4'd15, 86);
        send_frame();

        // Header lengths below five put the segment over the IP header
        build_tcp(1'b0, 4'd0, MIN_LEN);
        send_frame();
        build_tcp(1'b0, 4'd3, 40);
        send_frame();

        // Wrong IPv4 version
        build_tcp(1'b0, 4'd5, MIN_LEN);
        pkt[OFS_VER] = {IPV6_VER, 4'd5};
        send_frame();

        // Fragment offset in the low byte; flags alone still pass
        build_tcp(1'b0, 4'd5, MIN_LEN);
        pkt[OFS_FRAG + 1] = 8'h01;
        send_frame();
        build_tcp(1'b0, 4'd5, 46);
        pkt[OFS_FRAG] = FLAG_MASK;
        send_frame();

        build_tcp(1'b0, 4'd5, MIN_LEN);
        pkt[OFS_PROTO4] = PROTO_UDP;
        send_frame();

        // Other EtherType
        build_tcp(1'b0, 4'd5, MIN_LEN);
        set_type(ETH_ARP);
        send_frame();

        // Shortest IPv6 segment (addresses 22..53, TCP 54..65) with all ones,
        // then one byte short
        build_tcp(1'b1, 4'd0, V6_NEED);
        fill(22, 65, 8'hff);
        send_frame();
        build_tcp(1'b1, 4'd0, V6_NEED - 1);
        send_frame();
        build_tcp(1'b1, 4'd0, V6_NEED);
        pkt[OFS_NEXT6] = PROTO_UDP;
        send_frame();

        // Random frames
        frames = 0;
        while (bytes_sent < TOTAL_BYTES || frames <= PRESSURE_AT)
        begin
            calm <= (frames >= CALM_FIRST && frames < CALM_END);
            if (frames == PRESSURE_AT)
            begin
                // hold the verdict side off while runts keep coming
                hold_trigger <= 1'b1;
                repeat (PRESSURE_FRAMES)
                begin
                    build_tcp(1'b0, 4'd5, $urandom_range(1, 3));
                    send_frame();
                end
            end
            build_random();
            send_frame();
            frames++;
        end
        frame_ch.valid <= 1'b0;

        // Drain outstanding verdicts
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ eth_ip_tcp_header_extractor.f @@
rtl/ethtcp_pkg.sv
rtl/ethtcp_if.sv
rtl/ethtcp_capture.sv
rtl/ethtcp_verdict.sv
rtl/eth_ip_tcp_header_extractor.sv
verif/ethtcp_verdict_checker.sv
verif/eth_ip_tcp_header_extractor_tb.sv
